[design/matrix_multiply_engine_assert.svh]
// ============================================================================
// Assertion macros for the matrix multiply engine
// Concurrent assertion wrappers. Define NO_ASSERTIONS to compile them away.
// ============================================================================
`ifndef MATRIX_MULTIPLY_ENGINE_ASSERT_SVH
`define MATRIX_MULTIPLY_ENGINE_ASSERT_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication, checked outside reset.
`define ASSERT_IMPLIES(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ASSERT_IMPLIES(label, clk, rstn, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rstn, ante, cons, msg)
`endif

`endif

[design/mme_pkg.sv]
// ============================================================================
// Matrix multiply engine package
// Shared widths, register indexes and the controller-to-datapath command.
// ============================================================================
package mme_pkg;

    localparam int DIM_W     = 4;   // width of a dimension register
    localparam int IDX_W     = 3;   // width of a row or column index
    localparam int CFG_IDX_W = 2;   // width of the register index
    localparam int FRAC_BITS = 16;  // fractional bits of the Q16.16 format

    localparam logic [CFG_IDX_W-1:0] REG_A_ROWS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_A_COLS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_B_ROWS = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_B_COLS = 2'd3;

    // Command from the controller to the datapath for one cycle.
    typedef struct packed {
        logic wr_a;       // write the input element into the A store
        logic wr_b;       // write the input element into the B store
        logic rd_en;      // read one A and one B operand
        logic first;      // operand pair starts a new dot product
        logic last;       // operand pair ends the dot product
        logic load_zero;  // load a zero product for the error beat
    } dp_cmd_t;

endpackage

[design/matrix_multiply_engine.sv]
// ============================================================================
// Matrix multiply engine
// Streams in A then B row-major, stores both, then sends C = A x B in Q16.16.
// ============================================================================
//
//  Channel  Direction  Handshake             Payload
//  -------  ---------  --------------------  --------------------------------------
//  in       in         in_valid / in_stall   element
//  cfg      in         cfg_valid / cfg_ready cfg_index, cfg_data
//  out      out        out_valid / out_stall product, out_row, out_col, last, dim_error
//
//  Loading takes one element beat per cycle while no configuration write is pending,
//  until a_rows*a_cols + b_rows*b_cols elements are stored; the input then stalls
//  until every result is issued. For each result element one operand pair per cycle
//  is read from the two stores, then goes through the multiplier, rounding,
//  accumulator and result register.
//  Reset clears the dimension registers to one and restarts loading; the stores
//  themselves are not cleared. A stalled result holds the result register and
//  the sequencer waits before starting the next dot product.
//
//  A dimension of zero acts as one and a dimension above MAX_DIM acts as
//  MAX_DIM. A configuration write restarts loading with the first element of A.
//  When a_cols differs from b_rows, all elements are still taken and a single
//  result beat comes back with product zero, last set and dim_error set.
//  Each product is rounded half up to Q16.16, the sum is kept exact and then
//  saturated to the signed element range.
//
module matrix_multiply_engine
    import mme_pkg::*;
#(
    parameter int MAX_DIM    = 8,
    parameter int ELEM_WIDTH = 32
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    // element input channel
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic signed [ELEM_WIDTH-1:0] element,
    // configuration write channel
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [CFG_IDX_W-1:0]         cfg_index,
    input  logic [DIM_W-1:0]             cfg_data,
    // result channel
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic signed [ELEM_WIDTH-1:0] product,
    output logic [IDX_W-1:0]             out_row,
    output logic [IDX_W-1:0]             out_col,
    output logic                         last,
    output logic                         dim_error
);

    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    dp_cmd_t       cmd;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] rd_a_addr;
    logic [AW-1:0] rd_b_addr;
    logic          sum_done;

    // The controller owns the dimensions, the load count and the result order.
    mme_ctrl #(
        .MAX_DIM (MAX_DIM)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_row   (out_row),
        .out_col   (out_col),
        .last      (last),
        .dim_error (dim_error),
        .cmd       (cmd),
        .wr_addr   (wr_addr),
        .rd_a_addr (rd_a_addr),
        .rd_b_addr (rd_b_addr),
        .sum_done  (sum_done)
    );

    // The datapath holds both stores and the multiply-accumulate pipeline.
    mme_datapath #(
        .MAX_DIM    (MAX_DIM),
        .ELEM_WIDTH (ELEM_WIDTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .wr_addr   (wr_addr),
        .rd_a_addr (rd_a_addr),
        .rd_b_addr (rd_b_addr),
        .element   (element),
        .sum_done  (sum_done),
        .product   (product)
    );

endmodule

[design/mme_datapath.sv]
// ============================================================================
// Matrix multiply engine datapath
// Operand stores, multiplier, rounding stage, accumulator and result register.
// ============================================================================
module mme_datapath
    import mme_pkg::*;
#(
    parameter int MAX_DIM    = 8,
    parameter int ELEM_WIDTH = 32
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  dp_cmd_t                      cmd,
    input  logic [((MAX_DIM*MAX_DIM > 1) ? $clog2(MAX_DIM*MAX_DIM) : 1)-1:0] wr_addr,
    input  logic [((MAX_DIM*MAX_DIM > 1) ? $clog2(MAX_DIM*MAX_DIM) : 1)-1:0] rd_a_addr,
    input  logic [((MAX_DIM*MAX_DIM > 1) ? $clog2(MAX_DIM*MAX_DIM) : 1)-1:0] rd_b_addr,
    input  logic signed [ELEM_WIDTH-1:0] element,
    output logic                         sum_done,
    output logic signed [ELEM_WIDTH-1:0] product
);

    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int ACC_W = 2 * ELEM_WIDTH + 4;
    localparam logic signed [ACC_W-1:0] HALF_LSB =
        {{(ACC_W-FRAC_BITS){1'b0}}, 1'b1, {(FRAC_BITS-1){1'b0}}};
    localparam logic signed [ACC_W-1:0] SAT_HI =
        {{(ACC_W-ELEM_WIDTH+1){1'b0}}, {(ELEM_WIDTH-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] SAT_LO = ~SAT_HI;

    logic [ELEM_WIDTH-1:0]          a_mem [DEPTH];
    logic [ELEM_WIDTH-1:0]          b_mem [DEPTH];
    logic [ELEM_WIDTH-1:0]          a_rd_reg;
    logic [ELEM_WIDTH-1:0]          b_rd_reg;
    logic signed [2*ELEM_WIDTH-1:0] mul_reg;
    logic signed [ACC_W-1:0]        mul_ext;
    logic signed [ACC_W-1:0]        rnd_sum;
    logic signed [ACC_W-1:0]        rnd_reg;
    logic signed [ACC_W-1:0]        acc_reg;
    logic signed [ELEM_WIDTH-1:0]   sat_value;
    logic signed [ELEM_WIDTH-1:0]   prod_reg;
    logic                           s1_valid_reg, s1_first_reg, s1_last_reg;
    logic                           s2_valid_reg, s2_first_reg, s2_last_reg;
    logic                           s3_valid_reg, s3_first_reg, s3_last_reg;
    logic                           done_reg;

    // Operand stores: one write and one registered read per cycle each.
    always_ff @(posedge clk)
    begin
        if (cmd.wr_a)
        begin
            a_mem[wr_addr] <= element;
        end
        if (cmd.wr_b)
        begin
            b_mem[wr_addr] <= element;
        end
        if (cmd.rd_en)
        begin
            a_rd_reg <= a_mem[rd_a_addr];
            b_rd_reg <= b_mem[rd_b_addr];
        end
    end

    // Round half up to Q16.16 by adding half an LSB and shifting with floor.
    assign mul_ext = {{(ACC_W-2*ELEM_WIDTH){mul_reg[2*ELEM_WIDTH-1]}}, mul_reg};
    assign rnd_sum = mul_ext + HALF_LSB;

    always_comb
    begin
        priority if (acc_reg > SAT_HI)
        begin
            sat_value = {1'b0, {(ELEM_WIDTH-1){1'b1}}};
        end
        else if (acc_reg < SAT_LO)
        begin
            sat_value = {1'b1, {(ELEM_WIDTH-1){1'b0}}};
        end
        else
        begin
            sat_value = acc_reg[ELEM_WIDTH-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        mul_reg <= $signed(a_rd_reg) * $signed(b_rd_reg);
        rnd_reg <= rnd_sum >>> FRAC_BITS;
        if (s3_valid_reg)
        begin
            acc_reg <= s3_first_reg ? rnd_reg : acc_reg + rnd_reg;
        end
        if (done_reg)
        begin
            prod_reg <= sat_value;
        end
        else if (cmd.load_zero)
        begin
            prod_reg <= '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s1_first_reg <= 1'b0;
            s1_last_reg  <= 1'b0;
            s2_valid_reg <= 1'b0;
            s2_first_reg <= 1'b0;
            s2_last_reg  <= 1'b0;
            s3_valid_reg <= 1'b0;
            s3_first_reg <= 1'b0;
            s3_last_reg  <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= cmd.rd_en;
            s1_first_reg <= cmd.first;
            s1_last_reg  <= cmd.last;
            s2_valid_reg <= s1_valid_reg;
            s2_first_reg <= s1_first_reg;
            s2_last_reg  <= s1_last_reg;
            s3_valid_reg <= s2_valid_reg;
            s3_first_reg <= s2_first_reg;
            s3_last_reg  <= s2_last_reg;
            done_reg     <= s3_valid_reg && s3_last_reg;
        end
    end

    assign sum_done = done_reg;
    assign product  = prod_reg;

endmodule

[design/mme_ctrl.sv]
// ============================================================================
// Matrix multiply engine controller
// Configuration registers, load counter and the result sequencer.
// ============================================================================
`include "matrix_multiply_engine_assert.svh"

module mme_ctrl
    import mme_pkg::*;
#(
    parameter int MAX_DIM = 8
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DIM_W-1:0]     cfg_data,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [IDX_W-1:0]     out_row,
    output logic [IDX_W-1:0]     out_col,
    output logic                 last,
    output logic                 dim_error,
    output dp_cmd_t              cmd,
    output logic [((MAX_DIM*MAX_DIM > 1) ? $clog2(MAX_DIM*MAX_DIM) : 1)-1:0] wr_addr,
    output logic [((MAX_DIM*MAX_DIM > 1) ? $clog2(MAX_DIM*MAX_DIM) : 1)-1:0] rd_a_addr,
    output logic [((MAX_DIM*MAX_DIM > 1) ? $clog2(MAX_DIM*MAX_DIM) : 1)-1:0] rd_b_addr,
    input  logic                 sum_done
);

    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(2 * DEPTH + 1);

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_WAIT,
        ST_ISSUE,
        ST_DRAIN,
        ST_ERR
    } state_t;

    state_t           state_reg;
    logic [DIM_W-1:0] a_rows_reg, a_cols_reg, b_rows_reg, b_cols_reg;
    logic [CNT_W-1:0] load_cnt_reg;
    logic [IDX_W-1:0] i_reg, j_reg, k_reg;
    logic [AW-1:0]    row_base_reg, a_addr_reg, b_addr_reg;
    logic             out_valid_reg, out_last_reg, dim_err_reg;
    logic [IDX_W-1:0] out_row_reg, out_col_reg;

    logic [DIM_W-1:0] ar, ac, br, bc;
    logic [CNT_W-1:0] a_size, total, cnt_inc, b_off;
    logic             in_take, cfg_take, in_a, slot_free, load_out;
    logic             row_last, col_last, k_last;
    logic [IDX_W-1:0] i_next, j_next;
    logic [AW-1:0]    base_next;

    // Out-of-range dimensions: zero acts as one, anything above the maximum
    // acts as the maximum.
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
        if (v == '0)
        begin
            return DIM_W'(1);
        end
        else if (int'(v) > MAX_DIM)
        begin
            return DIM_W'(MAX_DIM);
        end
        return v;
    endfunction

    assign ar = clamp_dim(a_rows_reg);
    assign ac = clamp_dim(a_cols_reg);
    assign br = clamp_dim(b_rows_reg);
    assign bc = clamp_dim(b_cols_reg);

    assign a_size  = CNT_W'(ar) * CNT_W'(ac);
    assign total   = a_size + CNT_W'(br) * CNT_W'(bc);
    assign cnt_inc = load_cnt_reg + CNT_W'(1);
    assign b_off   = load_cnt_reg - a_size;
    assign in_a    = load_cnt_reg < a_size;

    assign cfg_ready = (state_reg == ST_LOAD);
    assign in_stall  = (state_reg != ST_LOAD) || cfg_valid;
    assign in_take   = in_valid && !in_stall;
    assign cfg_take  = cfg_valid && cfg_ready;
    assign slot_free = !out_valid_reg || !out_stall;

    assign row_last = (i_reg == IDX_W'(ar - DIM_W'(1)));
    assign col_last = (j_reg == IDX_W'(bc - DIM_W'(1)));
    assign k_last   = (k_reg == IDX_W'(ac - DIM_W'(1)));

    assign i_next    = col_last ? i_reg + IDX_W'(1) : i_reg;
    assign j_next    = col_last ? '0 : j_reg + IDX_W'(1);
    assign base_next = col_last ? row_base_reg + AW'(ac) : row_base_reg;

    assign load_out = ((state_reg == ST_DRAIN) && sum_done)
                   || ((state_reg == ST_ERR) && slot_free);

    always_comb
    begin
        cmd.wr_a      = in_take && in_a;
        cmd.wr_b      = in_take && !in_a;
        cmd.rd_en     = (state_reg == ST_ISSUE);
        cmd.first     = (k_reg == '0);
        cmd.last      = k_last;
        cmd.load_zero = (state_reg == ST_ERR) && slot_free;
    end

    assign wr_addr   = in_a ? load_cnt_reg[AW-1:0] : b_off[AW-1:0];
    assign rd_a_addr = a_addr_reg;
    assign rd_b_addr = b_addr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            a_rows_reg    <= DIM_W'(1);
            a_cols_reg    <= DIM_W'(1);
            b_rows_reg    <= DIM_W'(1);
            b_cols_reg    <= DIM_W'(1);
            load_cnt_reg  <= '0;
            i_reg         <= '0;
            j_reg         <= '0;
            k_reg         <= '0;
            row_base_reg  <= '0;
            a_addr_reg    <= '0;
            b_addr_reg    <= '0;
            out_valid_reg <= 1'b0;
            out_row_reg   <= '0;
            out_col_reg   <= '0;
            out_last_reg  <= 1'b0;
            dim_err_reg   <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                ST_LOAD:
                begin
                    if (cfg_take)
                    begin
                        unique case (cfg_index)
                            REG_A_ROWS: a_rows_reg <= cfg_data;
                            REG_A_COLS: a_cols_reg <= cfg_data;
                            REG_B_ROWS: b_rows_reg <= cfg_data;
                            REG_B_COLS: b_cols_reg <= cfg_data;
                        endcase
                        load_cnt_reg <= '0;
                    end
                    else if (in_take)
                    begin
                        if (cnt_inc == total)
                        begin
                            load_cnt_reg <= '0;
                            i_reg        <= '0;
                            j_reg        <= '0;
                            k_reg        <= '0;
                            row_base_reg <= '0;
                            a_addr_reg   <= '0;
                            b_addr_reg   <= '0;
                            state_reg    <= (ac != br) ? ST_ERR : ST_WAIT;
                        end
                        else
                        begin
                            load_cnt_reg <= cnt_inc;
                        end
                    end
                end
                ST_WAIT:
                begin
                    if (slot_free)
                    begin
                        state_reg <= ST_ISSUE;
                    end
                end
                ST_ISSUE:
                begin
                    if (k_last)
                    begin
                        state_reg <= ST_DRAIN;
                    end
                    else
                    begin
                        k_reg      <= k_reg + IDX_W'(1);
                        a_addr_reg <= a_addr_reg + AW'(1);
                        b_addr_reg <= b_addr_reg + AW'(bc);
                    end
                end
                ST_DRAIN:
                begin
                    if (sum_done)
                    begin
                        out_row_reg  <= i_reg;
                        out_col_reg  <= j_reg;
                        out_last_reg <= row_last && col_last;
                        dim_err_reg  <= 1'b0;
                        if (row_last && col_last)
                        begin
                            state_reg <= ST_LOAD;
                        end
                        else
                        begin
                            i_reg        <= i_next;
                            j_reg        <= j_next;
                            k_reg        <= '0;
                            row_base_reg <= base_next;
                            a_addr_reg   <= base_next;
                            b_addr_reg   <= AW'(j_next);
                            state_reg    <= ST_WAIT;
                        end
                    end
                end
                ST_ERR:
                begin
                    if (slot_free)
                    begin
                        out_row_reg  <= '0;
                        out_col_reg  <= '0;
                        out_last_reg <= 1'b1;
                        dim_err_reg  <= 1'b1;
                        state_reg    <= ST_LOAD;
                    end
                end
                default:
                begin
                    state_reg <= ST_LOAD;
                end
            endcase

            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_row   = out_row_reg;
    assign out_col   = out_col_reg;
    assign last      = out_last_reg;
    assign dim_error = dim_err_reg;

    `ASSERT_IMPLIES(a_done_in_drain, clk, rst_n, sum_done, state_reg == ST_DRAIN, "sum done outside drain")
    `ASSERT_IMPLIES(a_issue_slot_empty, clk, rst_n, state_reg == ST_ISSUE, !out_valid_reg, "issue with result pending")
    `ASSERT_IMPLIES(a_cnt_idle, clk, rst_n, state_reg != ST_LOAD, load_cnt_reg == '0, "load count not cleared")
    `ASSERT_IMPLIES(a_err_mismatch, clk, rst_n, state_reg == ST_ERR, ac != br, "error without mismatch")
    `ASSERT_NEXT(a_err_beat, clk, rst_n, (state_reg == ST_ERR) && slot_free, out_valid_reg && dim_err_reg && out_last_reg, "error beat not shown")

endmodule
